@@ rtl/core/bmm_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the bracket marker.
`timescale 1ns / 1ps
`default_nettype none
package bmm_pkg;

    localparam int DEF_MAX_LEN = 256;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] MARK_BLANK = 2'd0;
    localparam logic [1:0] MARK_OPEN  = 2'd1;
    localparam logic [1:0] MARK_CLOSE = 2'd2;

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    typedef struct packed {
        logic append;
        logic push;
        logic pop_rd;
        logic partner_clr;
        logic rd_issue;
        logic out_load;
        logic clear;
        logic set_ovf;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic stack_empty;
        logic is_open;
        logic is_close;
    } sts_t;

endpackage
`default_nettype wire

@@ rtl/core/bmm_datapath.sv @@
// Datapath of the bracket marker: character, mark and open-position memories and counters.
`timescale 1ns / 1ps
`default_nettype none
module bmm_datapath
    import bmm_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] char_code,
    input  wire logic [7:0] position,
    input  wire cmd_t       cmd,
    output sts_t            sts,
    output logic [1:0]      mark,
    output logic [7:0]      stored_char,
    output logic            out_of_range,
    output logic            overflowed
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = ((LW > 8) ? LW : 8) + 1;

    logic [1:0]    mark_mem  [MAX_LEN];
    logic [7:0]    char_mem  [MAX_LEN];
    logic [AW-1:0] stack_mem [MAX_LEN];

    logic [LW-1:0] length_reg, length_next;
    logic [LW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          oor_reg;
    logic [AW-1:0] partner_reg;
    logic [1:0]    rd_mark_reg;
    logic [7:0]    rd_char_reg;
    logic [1:0]    mark_reg;
    logic [7:0]    char_reg;
    logic          oor_out_reg;
    logic          ovf_out_reg;

    logic [AW-1:0] wr_addr;
    logic [AW-1:0] top_addr;
    logic [AW-1:0] rd_addr;
    logic [LW-1:0] count_dec;
    logic [1:0]    mark_new;
    logic          mark_we;
    logic [AW-1:0] mark_addr;
    logic [1:0]    mark_data;
    logic [CW-1:0] pos_ext;
    logic          oor;

    assign wr_addr   = length_reg[AW-1:0];
    assign count_dec = count_reg - LW'(1);
    assign top_addr  = count_dec[AW-1:0];
    assign rd_addr   = AW'(position);
    assign pos_ext   = CW'(position);
    assign oor       = !((pos_ext < CW'(length_reg)) && (pos_ext < CW'(MAX_LEN)));

    assign sts.full        = (length_reg == LW'(MAX_LEN));
    assign sts.stack_empty = (count_reg == '0);
    assign sts.is_open     = (char_code == CH_OPEN);
    assign sts.is_close    = (char_code == CH_CLOSE);

    always_comb
    begin
        if (sts.is_open)
        begin
            mark_new = MARK_OPEN;
        end
        else if (sts.is_close && sts.stack_empty)
        begin
            mark_new = MARK_CLOSE;
        end
        else
        begin
            mark_new = MARK_BLANK;
        end
    end

    assign mark_we   = cmd.append || cmd.partner_clr;
    assign mark_addr = cmd.partner_clr ? partner_reg : wr_addr;
    assign mark_data = cmd.partner_clr ? MARK_BLANK : mark_new;

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_addr] <= mark_data;
        end
        if (cmd.append)
        begin
            char_mem[wr_addr] <= char_code;
        end
        if (cmd.push)
        begin
            stack_mem[count_reg[AW-1:0]] <= wr_addr;
        end
        if (cmd.pop_rd)
        begin
            partner_reg <= stack_mem[top_addr];
        end
        if (cmd.rd_issue)
        begin
            rd_mark_reg <= mark_mem[rd_addr];
            rd_char_reg <= char_mem[rd_addr];
            oor_reg     <= oor;
        end
        if (cmd.out_load)
        begin
            mark_reg    <= oor_reg ? MARK_BLANK : rd_mark_reg;
            char_reg    <= oor_reg ? 8'd0 : rd_char_reg;
            oor_out_reg <= oor_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    always_comb
    begin
        length_next = length_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        if (cmd.clear)
        begin
            length_next = '0;
            count_next  = '0;
            ovf_next    = 1'b0;
        end
        else
        begin
            if (cmd.append)
            begin
                length_next = length_reg + LW'(1);
            end
            if (cmd.push)
            begin
                count_next = count_reg + LW'(1);
            end
            else if (cmd.pop_rd)
            begin
                count_next = count_dec;
            end
            if (cmd.set_ovf)
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            length_reg <= length_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
        end
    end

    assign mark         = mark_reg;
    assign stored_char  = char_reg;
    assign out_of_range = oor_out_reg;
    assign overflowed   = ovf_out_reg;

    a_count_le_length: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= length_reg)
        else $error("open stack deeper than string");

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= LW'(MAX_LEN))
        else $error("string length past capacity");

endmodule
`default_nettype wire

@@ rtl/core/bmm_ctrl.sv @@
// Controller of the bracket marker: transaction sequencing and output valid.
`timescale 1ns / 1ps
`default_nettype none
module bmm_ctrl
    import bmm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] op,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire sts_t       sts,
    output cmd_t            cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POP  = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_APPEND:
                        begin
                            if (sts.full)
                            begin
                                cmd.set_ovf = 1'b1;
                            end
                            else
                            begin
                                cmd.append = 1'b1;
                                cmd.push   = sts.is_open;
                                if (sts.is_close && !sts.stack_empty)
                                begin
                                    cmd.pop_rd = 1'b1;
                                    state_next = ST_POP;
                                end
                            end
                        end
                        OP_READ:
                        begin
                            cmd.rd_issue = 1'b1;
                            state_next   = ST_RD;
                        end
                        OP_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                cmd.partner_clr = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_RD:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_rd |-> (!sts.stack_empty && cmd.append))
        else $error("pop issued on empty stack");

    a_append_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> !sts.full)
        else $error("append issued with store full");

    a_rd_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("read result not loaded");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.append, cmd.rd_issue, cmd.clear, cmd.partner_clr,
                  cmd.set_ovf, cmd.out_load}))
        else $error("conflicting datapath commands");

endmodule
`default_nettype wire

@@ rtl/core/bracket_match_marker_core.sv @@
// Top level of the bracket marker: controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
// Marks each position of a string as blank/matched, unmatched '(' or unmatched ')'.
// op 0 appends char_code, op 1 reads position (one result), op 2 clears, op 3 does
// nothing. Appends, clears and ignored ops complete in the idle state; an append
// of ')' that matches an open also passes through the pop state, because the open's
// position comes from the stack memory's registered read before its mark is cleared
// through the single mark write port. A read goes through the registered memory
// read, then waits for the output register to be free. Up to MAX_LEN characters
// are stored; further appends are dropped and set the sticky overflowed flag.
// No clearing pass after reset: stored data is only used below the string length.
module bracket_match_marker_core
    import bmm_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] op,
    input  wire logic [7:0] char_code,
    input  wire logic [7:0] position,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      mark,
    output logic [7:0]      stored_char,
    output logic            out_of_range,
    output logic            overflowed
);

    cmd_t cmd;
    sts_t sts;

    bmm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    bmm_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_code    (char_code),
        .position     (position),
        .cmd          (cmd),
        .sts          (sts),
        .mark         (mark),
        .stored_char  (stored_char),
        .out_of_range (out_of_range),
        .overflowed   (overflowed)
    );

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for the bracket marker core with a scoreboard-based read predictor.
`timescale 1ns / 1ps
module testbench;
    import bmm_pkg::*;

    localparam int          STORE_DEPTH  = DEF_MAX_LEN;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned PHASE_QUOTA  = 400;

    typedef struct packed {
        logic [1:0] mark;
        logic [7:0] stored_char;
        logic       out_of_range;
        logic       overflowed;
    } read_result_t;

    class marker_scoreboard;
        logic [7:0]   char_mem [STORE_DEPTH];
        logic [1:0]   mark_mem [STORE_DEPTH];
        int unsigned  open_mem [STORE_DEPTH];
        int unsigned  open_depth;
        int unsigned  str_len;
        bit           ovf_flag;
        read_result_t expected_reads[$];
        int unsigned  errors;

        function new();
            open_depth = 0;
            str_len    = 0;
            ovf_flag   = 1'b0;
            errors     = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("[%0t] %s", $realtime, msg);
        endfunction

        function void note_request(logic [1:0] o, logic [7:0] c, logic [7:0] p);
            read_result_t res;
            int unsigned  slot;
            case (o)
                OP_APPEND:
                begin
                    if (str_len >= STORE_DEPTH)
                    begin
                        ovf_flag = 1'b1;
                    end
                    else
                    begin
                        slot = str_len;
                        char_mem[slot] = c;
                        mark_mem[slot] = MARK_BLANK;
                        str_len++;
                        if (c == CH_OPEN)
                        begin
                            mark_mem[slot] = MARK_OPEN;
                            open_mem[open_depth] = slot;
                            open_depth++;
                        end
                        else if (c == CH_CLOSE)
                        begin
                            if (open_depth > 0)
                            begin
                                open_depth--;
                                mark_mem[open_mem[open_depth]] = MARK_BLANK;
                            end
                            else
                            begin
                                mark_mem[slot] = MARK_CLOSE;
                            end
                        end
                    end
                end
                OP_READ:
                begin
                    if (p < str_len)
                    begin
                        res.mark         = mark_mem[p];
                        res.stored_char  = char_mem[p];
                        res.out_of_range = 1'b0;
                    end
                    else
                    begin
                        res.mark         = MARK_BLANK;
                        res.stored_char  = 8'h00;
                        res.out_of_range = 1'b1;
                    end
                    res.overflowed = ovf_flag;
                    expected_reads.push_back(res);
                end
                OP_CLEAR:
                begin
                    str_len    = 0;
                    open_depth = 0;
                    ovf_flag   = 1'b0;
                end
                default: ;
            endcase
        endfunction

        function void check_read(read_result_t got);
            read_result_t want;
            if (expected_reads.size() == 0)
            begin
                report($sformatf("unexpected read result: mark %0d char %02h oor %0b ovf %0b",
                                 got.mark, got.stored_char, got.out_of_range, got.overflowed));
                return;
            end
            want = expected_reads.pop_front();
            if (got.mark !== want.mark || got.stored_char !== want.stored_char ||
                got.out_of_range !== want.out_of_range || got.overflowed !== want.overflowed)
                report($sformatf({"read mismatch: mark exp %0d got %0d, char exp %02h got %02h,",
                                  " oor exp %0b got %0b, ovf exp %0b got %0b"},
                                 want.mark, got.mark, want.stored_char, got.stored_char,
                                 want.out_of_range, got.out_of_range,
                                 want.overflowed, got.overflowed));
        endfunction

        function int unsigned pending();
            return expected_reads.size();
        endfunction
    endclass

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic [1:0] op           = OP_READ;
    logic [7:0] char_code    = 8'h00;
    logic [7:0] position     = 8'h00;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic [1:0] mark;
    logic [7:0] stored_char;
    logic       out_of_range;
    logic       overflowed;

    marker_scoreboard sb = new();

    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_served = 0;
    int unsigned cycle_count = 0;

    bracket_match_marker_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .char_code    (char_code),
        .position     (position),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mark         (mark),
        .stored_char  (stored_char),
        .out_of_range (out_of_range),
        .overflowed   (overflowed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served++;
                repeat (HOLD_CYCLES)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_read({mark, stored_char, out_of_range, overflowed});
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_char(int unsigned open_bias);
        int unsigned r;
        r = $urandom_range(99);
        if (r < open_bias)
            return CH_OPEN;
        if (r < 90)
            return CH_CLOSE;
        return rand_byte();
    endfunction

    function automatic logic [7:0] pick_position();
        int unsigned r;
        int unsigned len;
        r   = $urandom_range(99);
        len = sb.str_len;
        if (len > 0 && r < 70)
            return 8'($urandom_range(len - 1));
        if (len <= 255 && r < 85)
            return 8'(len);
        return rand_byte();
    endfunction

    task automatic send(input logic [1:0] o, input logic [7:0] c, input logic [7:0] p);
        bit taken;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= o;
        char_code <= c;
        position  <= p;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        sb.note_request(o, c, p);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input int unsigned quota, input bit with_long);
        int unsigned sent;
        int unsigned target;
        int unsigned appended;
        int unsigned open_bias;
        int unsigned r;
        bit          long_pending;
        bit          filling;
        sent = 0;
        long_pending = with_long;
        while (sent < quota)
        begin
            if ($urandom_range(99) < 85)
            begin
                send(OP_CLEAR, rand_byte(), rand_byte());
                sent++;
            end
            filling = long_pending;
            if (long_pending)
            begin
                target = STORE_DEPTH + $urandom_range(2, 8);
                long_pending = 1'b0;
            end
            else
            begin
                target = $urandom_range(1, 40);
            end
            open_bias = $urandom_range(20, 70);
            appended = 0;
            while (appended < target)
            begin
                r = $urandom_range(99);
                if (r < 62)
                begin
                    send(OP_APPEND, pick_char(open_bias), rand_byte());
                    appended++;
                    sent++;
                end
                else if (r < 94)
                begin
                    send(OP_READ, rand_byte(), pick_position());
                    sent++;
                end
                else if (r < 97)
                begin
                    send(OP_UNUSED, rand_byte(), rand_byte());
                end
                else if (r < 98 && !filling)
                begin
                    send(OP_CLEAR, rand_byte(), rand_byte());
                    sent++;
                end
                else
                begin
                    send(OP_READ, rand_byte(), rand_byte());
                    sent++;
                end
            end
            repeat ($urandom_range(1, 4))
            begin
                send(OP_READ, rand_byte(), pick_position());
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [7:0] seq [9];
        seq = '{CH_CLOSE, CH_OPEN, CH_OPEN, 8'h41, CH_CLOSE, 8'h00, 8'hFF, CH_CLOSE, CH_OPEN};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_READ, rand_byte(), 8'h00);
        send(OP_UNUSED, rand_byte(), rand_byte());
        foreach (seq[i])
            send(OP_APPEND, seq[i], rand_byte());
        for (int i = 0; i < 9; i++)
            send(OP_READ, rand_byte(), 8'(i));
        send(OP_READ, rand_byte(), 8'd9);
        send(OP_READ, rand_byte(), 8'hFF);
        send(OP_CLEAR, rand_byte(), rand_byte());
        send(OP_READ, rand_byte(), 8'h00);
        drain();

        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_requests++;
        run_phase(PHASE_QUOTA, 1'b0);
        drain();

        sender_idle_pct = 52;
        receiver_stall_pct = 0;
        run_phase(PHASE_QUOTA, 1'b1);
        drain();

        sender_idle_pct = 0;
        receiver_stall_pct = 52;
        hold_requests++;
        run_phase(PHASE_QUOTA, 1'b0);
        drain();

        sender_idle_pct = 22;
        receiver_stall_pct = 22;
        run_phase(PHASE_QUOTA, 1'b1);
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
